// ----- rtl/srds_pkg.sv -----
// ============================================================================
// srds_pkg : shared types and constants for the sensor readout sequencer
// Display codes, phase encoding, register map, reciprocal constants and the
// small binary-to-digit helper used by the digit formatter.
// ============================================================================
package srds_pkg;

    // Display phase, also the phase code shown on the output
    typedef enum logic [1:0] {
        PHASE_WIND       = 2'd0,
        PHASE_WIND_BLANK = 2'd1,
        PHASE_TEMP       = 2'd2,
        PHASE_TEMP_BLANK = 2'd3
    } phase_t;

    // Seven-segment digit codes
    localparam logic [4:0] CODE_MINUS     = 5'd12;
    localparam logic [4:0] CODE_BLANK     = 5'd14;
    localparam logic [4:0] CODE_ZERO_TENS = 5'd10;
    localparam logic [4:0] POINT_OFFSET   = 5'd20;

    // Register map (word index into the APB window)
    localparam int          APB_ADDR_W   = 4;
    localparam int          APB_DATA_W   = 32;
    localparam int          DWELL_W      = 8;
    localparam logic [1:0]  REG_WIND_DWELL       = 2'd0;
    localparam logic [1:0]  REG_WIND_BLANK_DWELL = 2'd1;
    localparam logic [1:0]  REG_TEMP_DWELL       = 2'd2;
    localparam logic [1:0]  REG_TEMP_BLANK_DWELL = 2'd3;

    localparam logic [DWELL_W-1:0] RST_WIND_DWELL       = 8'd30;
    localparam logic [DWELL_W-1:0] RST_WIND_BLANK_DWELL = 8'd5;
    localparam logic [DWELL_W-1:0] RST_TEMP_DWELL       = 8'd10;
    localparam logic [DWELL_W-1:0] RST_TEMP_BLANK_DWELL = 8'd5;

    // Reciprocal multipliers, exact over the input ranges used:
    //   speed  = (delta >> 3) / 125  -> (x * 4195)  >> 19, x < 2^12
    //   sq_q   = (sq >> 4)   / 625   -> (x * 858994) >> 29, x < 2^19
    //   lin_q  = (8 * r)     / 25    -> (x * 10486) >> 18, x < 2^13
    localparam int SPEED_RECIP    = 4195;
    localparam int TEMP_SQ_RECIP  = 858994;
    localparam int TEMP_LIN_RECIP = 10486;
    localparam int TEMP_OFFSET    = 92995 / 10000;

    // Dwell settings handed from the register file to the sequencer
    typedef struct packed {
        logic [DWELL_W-1:0] wind;
        logic [DWELL_W-1:0] wind_gap;
        logic [DWELL_W-1:0] temp;
        logic [DWELL_W-1:0] temp_gap;
    } dwell_cfg_t;

    // Pre-scaled sensor values held in the input stage
    typedef struct packed {
        logic [5:0]  speed;       // delta / 1000
        logic [18:0] sq_scaled;   // (5 * r * r) >> 4
        logic [9:0]  adc_code;
    } sensor_t;

    typedef struct packed {
        logic [4:0] left;
        logic [4:0] middle;
        logic [4:0] right;
    } digits_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } bcd_t;

    // Split a value below 256 into decimal digits by compare and subtract
    function automatic bcd_t to_bcd(input logic [7:0] value);
        bcd_t       res;
        logic [7:0] rem;
        res = '0;
        if (value >= 8'd200) begin
            res.hundreds = 4'd2;
            rem          = value - 8'd200;
        end else if (value >= 8'd100) begin
            res.hundreds = 4'd1;
            rem          = value - 8'd100;
        end else begin
            rem = value;
        end
        res.units = rem[3:0];
        for (int k = 1; k < 10; k++) begin
            if (rem >= 8'(10 * k)) begin
                res.tens  = 4'(k);
                res.units = 4'(rem - 8'(10 * k));
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/srds_regs.sv -----
// ============================================================================
// srds_regs : APB dwell register file
// Four 8-bit dwell registers at byte addresses 0, 4, 8 and 12.
// ============================================================================
module srds_regs
    import srds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output dwell_cfg_t            dwell
);

    dwell_cfg_t dwell_reg;
    dwell_cfg_t dwell_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        dwell_next = dwell_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WIND_DWELL:       dwell_next.wind     = pwdata[DWELL_W-1:0];
                REG_WIND_BLANK_DWELL: dwell_next.wind_gap = pwdata[DWELL_W-1:0];
                REG_TEMP_DWELL:       dwell_next.temp     = pwdata[DWELL_W-1:0];
                REG_TEMP_BLANK_DWELL: dwell_next.temp_gap = pwdata[DWELL_W-1:0];
                default:              dwell_next = dwell_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg.wind     <= RST_WIND_DWELL;
            dwell_reg.wind_gap <= RST_WIND_BLANK_DWELL;
            dwell_reg.temp     <= RST_TEMP_DWELL;
            dwell_reg.temp_gap <= RST_TEMP_BLANK_DWELL;
        end
        else
        begin
            dwell_reg <= dwell_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIND_DWELL:       prdata = APB_DATA_W'(dwell_reg.wind);
            REG_WIND_BLANK_DWELL: prdata = APB_DATA_W'(dwell_reg.wind_gap);
            REG_TEMP_DWELL:       prdata = APB_DATA_W'(dwell_reg.temp);
            REG_TEMP_BLANK_DWELL: prdata = APB_DATA_W'(dwell_reg.temp_gap);
            default:              prdata = '0;
        endcase
    end

    assign dwell = dwell_reg;

endmodule

// ----- rtl/srds_digits.sv -----
// ============================================================================
// srds_digits : phase-dependent digit formatter
// Finish the temperature conversion and map wind, temperature or blank to
// three seven-segment digit codes.
// ============================================================================
module srds_digits
    import srds_pkg::*;
(
    input  phase_t  phase,
    input  sensor_t sensor,
    output digits_t digits
);

    logic [38:0]        sq_prod;
    logic [9:0]         sq_quot;
    logic [26:0]        lin_prod;
    logic [8:0]         lin_quot;
    logic signed [10:0] temp_val;
    logic [10:0]        temp_mag;
    bcd_t               wind_bcd;
    bcd_t               temp_bcd;

    // 5*r*r / 10000 and 32*r / 100 by reciprocal multiplication
    assign sq_prod  = {20'b0, sensor.sq_scaled} * 39'(TEMP_SQ_RECIP);
    assign sq_quot  = sq_prod[38:29];
    assign lin_prod = {14'b0, sensor.adc_code, 3'b000} * 27'(TEMP_LIN_RECIP);
    assign lin_quot = lin_prod[26:18];

    assign temp_val = $signed({2'b00, lin_quot}) - $signed({1'b0, sq_quot})
                    - $signed(11'(TEMP_OFFSET));
    assign temp_mag = temp_val[10] ? 11'(-temp_val) : temp_val;

    assign wind_bcd = to_bcd({2'b00, sensor.speed});
    assign temp_bcd = to_bcd(temp_mag[7:0]);

    always_comb
    begin
        digits.left   = CODE_BLANK;
        digits.middle = CODE_BLANK;
        digits.right  = CODE_BLANK;
        case (phase)
            PHASE_WIND:
            begin
                digits.left   = (wind_bcd.hundreds == 4'd0) ? CODE_BLANK
                                                            : {1'b0, wind_bcd.hundreds};
                digits.middle = (wind_bcd.tens == 4'd0) ? CODE_ZERO_TENS
                                : {1'b0, wind_bcd.tens} + POINT_OFFSET;
                digits.right  = {1'b0, wind_bcd.units};
            end
            PHASE_TEMP:
            begin
                digits.left   = temp_val[10] ? CODE_MINUS : CODE_BLANK;
                digits.middle = {1'b0, temp_bcd.tens};
                digits.right  = {1'b0, temp_bcd.units};
            end
            default:
            begin
                digits.left   = CODE_BLANK;
                digits.middle = CODE_BLANK;
                digits.right  = CODE_BLANK;
            end
        endcase
    end

endmodule

// ----- rtl/sensor_readout_display_sequencer.sv -----
// ============================================================================
// sensor_readout_display_sequencer : weather display readout sequencer
// Convert wind and temperature readings to seven-segment digit codes and step
// a four-phase wind / blank / temperature / blank display cycle.
// ============================================================================
// The block takes one request per clock while in_stall is low and returns one
// result per request. The first register holds the pre-scaled readings (wind
// speed delta/1000, the scaled square of the temperature code and the tick
// time); the second stage finishes the temperature formula, formats the digits
// for the phase in force and, in the same cycle, decides whether the phase
// advances. The phase and the last switch time form a loop within that stage,
// which sets the rate at one request per cycle when nothing stalls. A result
// waiting on a stalled output does not block the input register, so two
// requests can be in flight. The user must write dwell registers through the
// APB port only while no request is in flight; the block does not enforce it.
// ============================================================================
module sensor_readout_display_sequencer
    import srds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // Input request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [14:0]           wind_pulse_delta,
    input  logic [9:0]            raw_temp_adc,
    input  logic [15:0]           now_ticks,

    // Result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            shown_phase,
    output logic [4:0]            digit_left,
    output logic [4:0]            digit_middle,
    output logic [4:0]            digit_right
);

    dwell_cfg_t dwell;

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    sensor_t     s1_sensor_reg;
    sensor_t     s1_sensor_next;
    logic [15:0] s1_now_reg;

    // Sequencer state
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] last_switch_reg;
    logic [15:0] last_switch_next;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_phase_reg;
    digits_t     out_digits_reg;

    logic        in_fire;
    logic        move;
    logic        s2_free;
    logic [7:0]  dwell_sel;
    logic        advance;
    logic [19:0] temp_sq;
    logic [22:0] temp_sq5;
    logic [24:0] speed_prod;
    digits_t     digits;

    srds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dwell   (dwell)
    );

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or taken; the input
    // register frees when empty or when its request moves on.
    // ------------------------------------------------------------------
    assign s2_free  = ~out_valid_reg | ~out_stall;
    assign move     = s1_valid_reg & s2_free;
    assign in_stall = s1_valid_reg & ~s2_free;
    assign in_fire  = in_valid & ~in_stall;

    // ------------------------------------------------------------------
    // Pre-scale at the input: wind speed and the squared temperature term.
    // Each path holds a single multiplier ahead of the input register.
    // ------------------------------------------------------------------
    assign speed_prod = {13'b0, wind_pulse_delta[14:3]} * 25'(SPEED_RECIP);
    assign temp_sq    = {10'b0, raw_temp_adc} * {10'b0, raw_temp_adc};
    assign temp_sq5   = {1'b0, temp_sq, 2'b00} + {3'b000, temp_sq};

    always_comb
    begin
        s1_sensor_next.speed     = speed_prod[24:19];
        s1_sensor_next.sq_scaled = temp_sq5[22:4];
        s1_sensor_next.adc_code  = raw_temp_adc;
        s1_valid_next            = in_fire | (s1_valid_reg & ~move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sensor_reg <= s1_sensor_next;
            s1_now_reg    <= now_ticks;
        end
    end

    // ------------------------------------------------------------------
    // Digit formatting for the phase in force when the request moves on
    // ------------------------------------------------------------------
    srds_digits u_digits (
        .phase  (phase_reg),
        .sensor (s1_sensor_reg),
        .digits (digits)
    );

    // ------------------------------------------------------------------
    // Phase sequencing: advance once now passes last switch plus dwell.
    // The sum is 17 bits wide so a wrapped tick counter holds the phase.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (phase_reg)
            PHASE_WIND:       dwell_sel = dwell.wind;
            PHASE_WIND_BLANK: dwell_sel = dwell.wind_gap;
            PHASE_TEMP:       dwell_sel = dwell.temp;
            PHASE_TEMP_BLANK: dwell_sel = dwell.temp_gap;
            default:          dwell_sel = dwell.wind;
        endcase
    end

    assign advance = {1'b0, s1_now_reg} > ({1'b0, last_switch_reg} + {9'b0, dwell_sel});

    always_comb
    begin
        phase_next       = phase_reg;
        last_switch_next = last_switch_reg;
        if (move && advance)
        begin
            phase_next       = phase_t'(phase_reg + 2'd1);
            last_switch_next = s1_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PHASE_WIND;
            last_switch_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            last_switch_reg <= last_switch_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on move, drop once taken.
    // ------------------------------------------------------------------
    assign out_valid_next = move | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_phase_reg  <= phase_reg;
            out_digits_reg <= digits;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shown_phase  = out_phase_reg;
    assign digit_left   = out_digits_reg.left;
    assign digit_middle = out_digits_reg.middle;
    assign digit_right  = out_digits_reg.right;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_held_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !move) |=> s1_valid_reg)
        else $error("waiting request lost from the input register");

    a_phase_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(phase_reg) && $stable(last_switch_reg))
        else $error("sequencer state changed without a request");

    a_phase_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (move && advance) |=> (phase_reg == phase_t'($past(phase_reg) + 2'd1))
                              && (last_switch_reg == $past(s1_now_reg)))
        else $error("phase advance did not step once and record the tick time");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg && (out_phase_reg == $past(phase_reg)))
        else $error("result register missed a moving request");

endmodule

// ----- verif/srds_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// srds_checker : result checker for the sensor readout display sequencer
// Watch the APB, request and result channels, keep a private copy of the
// dwell settings and display state, predict the digit codes of each accepted
// request and compare every accepted result against the oldest prediction.
// ============================================================================
module srds_checker
    import srds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [14:0]           wind_pulse_delta,
    input  logic [9:0]            raw_temp_adc,
    input  logic [15:0]           now_ticks,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            shown_phase,
    input  logic [4:0]            digit_left,
    input  logic [4:0]            digit_middle,
    input  logic [4:0]            digit_right,
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked
);

    localparam int TEMP_BIAS  = 92995 / 10000;

    typedef struct packed {
        phase_t  phase;
        digits_t digits;
    } readout_t;

    readout_t    readout_queue[$];
    dwell_cfg_t  dwell;
    phase_t      phase_now;
    logic [15:0] switch_time;

    // Digit codes for the phase in force when a request arrives
    function automatic readout_t format_readout(input phase_t ph, input logic [14:0] delta,
                                                input logic [9:0] raw);
        readout_t ro;
        int       speed;
        int       r;
        int       temp_c;
        int       mag;
        ro.phase         = ph;
        ro.digits.left   = CODE_BLANK;
        ro.digits.middle = CODE_BLANK;
        ro.digits.right  = CODE_BLANK;
        case (ph)
            PHASE_WIND: begin
                speed = int'(delta) / 1000;
                if ((speed / 100) % 10 != 0)
                    ro.digits.left = 5'((speed / 100) % 10);
                if ((speed / 10) % 10 == 0)
                    ro.digits.middle = CODE_ZERO_TENS;
                else
                    ro.digits.middle = 5'((speed / 10) % 10) + POINT_OFFSET;
                ro.digits.right = 5'(speed % 10);
            end
            PHASE_TEMP: begin
                r      = int'(raw);
                temp_c = (32 * r) / 100 - (5 * r * r) / 10000 - TEMP_BIAS;
                mag    = (temp_c < 0) ? -temp_c : temp_c;
                if (temp_c < 0)
                    ro.digits.left = CODE_MINUS;
                ro.digits.middle = 5'((mag / 10) % 10);
                ro.digits.right  = 5'(mag % 10);
            end
            default: ;
        endcase
        return ro;
    endfunction

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        readout_t    want;
        logic [7:0]  dwell_now;
        if (!rst_n) begin
            readout_queue.delete();
            dwell.wind       = RST_WIND_DWELL;
            dwell.wind_gap   = RST_WIND_BLANK_DWELL;
            dwell.temp       = RST_TEMP_DWELL;
            dwell.temp_gap   = RST_TEMP_BLANK_DWELL;
            phase_now        = PHASE_WIND;
            switch_time      = '0;
            mismatches       = 0;
            pending          = 0;
            results_checked  = 0;
        end else begin
            // Retire results before queueing this edge's request
            if (out_valid && !out_stall) begin
                if (readout_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request waiting, %s %0d %0d %0d %0d",
                             $time, "expected none, actual", shown_phase, digit_left,
                             digit_middle, digit_right);
                end else begin
                    want = readout_queue.pop_front();
                    results_checked++;
                    check_field("shown_phase", 5'(want.phase), 5'(shown_phase));
                    check_field("digit_left", want.digits.left, digit_left);
                    check_field("digit_middle", want.digits.middle, digit_middle);
                    check_field("digit_right", want.digits.right, digit_right);
                end
            end
            if (in_valid && !in_stall) begin
                readout_queue.push_back(format_readout(phase_now, wind_pulse_delta,
                                                       raw_temp_adc));
                case (phase_now)
                    PHASE_WIND:       dwell_now = dwell.wind;
                    PHASE_WIND_BLANK: dwell_now = dwell.wind_gap;
                    PHASE_TEMP:       dwell_now = dwell.temp;
                    default:          dwell_now = dwell.temp_gap;
                endcase
                // 17-bit sum: a wrapped tick count holds the phase
                if ({1'b0, now_ticks} > {1'b0, switch_time} + 17'(dwell_now)) begin
                    switch_time = now_ticks;
                    phase_now   = phase_t'(2'(phase_now + 2'd1));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIND_DWELL:       dwell.wind     = pwdata[7:0];
                    REG_WIND_BLANK_DWELL: dwell.wind_gap = pwdata[7:0];
                    REG_TEMP_DWELL:       dwell.temp     = pwdata[7:0];
                    REG_TEMP_BLANK_DWELL: dwell.temp_gap = pwdata[7:0];
                    default: ;
                endcase
            end
            pending = readout_queue.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench : stimulus and verdict for the sensor readout display sequencer
// Drive a directed walk through all four display phases, then random sensor
// requests with a mostly rising tick count under several dwell settings and
// flow-control patterns. The checker beside the block predicts and compares.
// ============================================================================
module testbench;
    import srds_pkg::*;

    // Flow-control patterns applied to each dwell setting in turn
    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    localparam int SETTING_COUNT     = 6;
    localparam int REQS_PER_SEGMENT  = 80;
    localparam int DRAIN_CYCLES      = 4;
    localparam int TICK_CEILING      = 65000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [14:0]           wind_pulse_delta;
    logic [9:0]            raw_temp_adc;
    logic [15:0]           now_ticks;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            shown_phase;
    logic [4:0]            digit_left;
    logic [4:0]            digit_middle;
    logic [4:0]            digit_right;

    int mismatches;
    int pending;
    int results_checked;
    int requests_sent = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;

    sensor_readout_display_sequencer DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .wind_pulse_delta (wind_pulse_delta),
        .raw_temp_adc     (raw_temp_adc),
        .now_ticks        (now_ticks),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .shown_phase      (shown_phase),
        .digit_left       (digit_left),
        .digit_middle     (digit_middle),
        .digit_right      (digit_right)
    );

    srds_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .wind_pulse_delta (wind_pulse_delta),
        .raw_temp_adc     (raw_temp_adc),
        .now_ticks        (now_ticks),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .shown_phase      (shown_phase),
        .digit_left       (digit_left),
        .digit_middle     (digit_middle),
        .digit_right      (digit_right),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_checked  (results_checked)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stall the result side at random; the rate follows the current pattern
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Offer one request: idle a random number of cycles first, then hold the
    // payload steady until an edge with valid high and stall low takes it.
    task automatic send_reading(input logic [14:0] delta, input logic [9:0] raw,
                                input logic [15:0] ticks);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        wind_pulse_delta <= delta;
        raw_temp_adc     <= raw;
        now_ticks        <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_dwell(input logic [1:0] index, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let every outstanding result arrive, then let the pipeline settle
    // before touching the registers
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int          tick;
        int          step;
        logic [15:0] req_ticks;
        logic [31:0] setting;
        int          wrap_ticks [5];

        wrap_ticks = '{65200, 65534, 65535, 0, 40};

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        wind_pulse_delta = '0;
        raw_temp_adc     = '0;
        now_ticks        = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk with the reset dwells (30, 5, 10, 5): field extremes,
        // dwell boundaries (equal holds, one past advances), a tick count
        // going backwards, zero tens in wind, negative temperatures and the
        // hidden hundreds digit of the coldest reading.
        send_reading(15'd0,     10'd0,    16'd0);
        send_reading(15'd32767, 10'd1023, 16'd30);
        send_reading(15'd9999,  10'd512,  16'd31);
        send_reading(15'd5000,  10'd100,  16'd36);
        send_reading(15'd5000,  10'd100,  16'd37);
        send_reading(15'd12345, 10'd0,    16'd40);
        send_reading(15'd12345, 10'd1023, 16'd20);
        send_reading(15'd777,   10'd600,  16'd47);
        send_reading(15'd777,   10'd320,  16'd48);
        send_reading(15'd31000, 10'd200,  16'd53);
        send_reading(15'd31000, 10'd200,  16'd54);
        send_reading(15'd10000, 10'd900,  16'd60);
        send_reading(15'd1000,  10'd900,  16'd85);
        send_reading(15'd20000, 10'd42,   16'd3);

        tick = 85;
        for (int s = 0; s < SETTING_COUNT; s++) begin
            // Settle the block, then load the next dwell set; the first set
            // keeps the reset values
            if (s > 0) begin
                drain_results();
                case (s)
                    1:       setting = {8'd0, 8'd0, 8'd0, 8'd0};
                    2:       setting = {4{8'd255}};
                    3:       setting = {8'd4, 8'd3, 8'd2, 8'd1};
                    4:       setting = {8'($urandom_range(63)), 8'($urandom_range(63)),
                                        8'($urandom_range(63)), 8'($urandom_range(63))};
                    default: setting = {8'd0, 8'd255, 8'd0, 8'd255};
                endcase
                write_dwell(REG_WIND_DWELL,       setting[7:0]);
                write_dwell(REG_WIND_BLANK_DWELL, setting[15:8]);
                write_dwell(REG_TEMP_DWELL,       setting[23:16]);
                write_dwell(REG_TEMP_BLANK_DWELL, setting[31:24]);
            end
            for (int m = FLOW_FREE; m <= FLOW_BOTH; m++) begin
                case (flow_mode_t'(m))
                    FLOW_FREE:       begin idle_pct = 0;  stall_pct = 0;  end
                    FLOW_SRC_IDLE:   begin idle_pct = 67; stall_pct = 0;  end
                    FLOW_SINK_STALL: begin idle_pct = 0;  stall_pct = 67; end
                    default:         begin idle_pct = 36; stall_pct = 36; end
                endcase
                repeat (REQS_PER_SEGMENT) begin
                    // Advance the tick count mostly in small steps so dwell
                    // edges are hit; the switch time only ever rises, so keep
                    // the count clear of the top until the very end
                    if ($urandom_range(99) < 75)
                        step = $urandom_range(3);
                    else
                        step = $urandom_range(80);
                    if (tick + step <= TICK_CEILING)
                        tick += step;
                    // Drop a stale tick count into one request in ten
                    if ($urandom_range(99) < 10)
                        req_ticks = 16'($urandom_range(tick));
                    else
                        req_ticks = 16'(tick);
                    send_reading(15'($urandom_range(32767)), 10'($urandom_range(1023)),
                                 req_ticks);
                end
            end
        end

        // Run the tick count up to the top and past zero; a wrapped count
        // holds the phase
        foreach (wrap_ticks[k])
            send_reading(15'($urandom_range(32767)), 10'($urandom_range(1023)),
                         16'(wrap_ticks[k]));

        stall_pct = 0;
        drain_results();

        $display("Summary: %0d requests over %0d dwell settings, each under free flow, %s",
                 requests_sent, SETTING_COUNT, "source gaps, sink stalls and both");
        $display("Summary: %0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
